@@ rtl/core/irr_pkg.sv @@
// ----------------------------------------------------------------------------
// Integer radix renderer package
// Widths, character codes, status codes and the digit glyph function used
// by the renderer, which also sizes its digit store from them.
// ----------------------------------------------------------------------------
package irr_pkg;

    localparam int VALUE_W     = 64;
    localparam int INT_WIDTH   = 64;
    localparam int RADIX_W     = 6;
    localparam int CAP_W       = 16;
    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 7;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int BIT_W       = $clog2(INT_WIDTH);

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_DEC = RADIX_W'(10);

    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LETTER = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_NONE   = 8'h00;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ACCESS = 2'd1,
        ST_RANGE  = 2'd2
    } t_status;

    function automatic logic [CHAR_W-1:0] glyph(input logic [RADIX_W-1:0] digit);
        logic [CHAR_W-1:0] d;
        d = {{(CHAR_W-RADIX_W){1'b0}}, digit};
        if (digit < RADIX_DEC) begin
            return CHAR_ZERO + d;
        end else begin
            return CHAR_LETTER + d - {{(CHAR_W-RADIX_W){1'b0}}, RADIX_DEC};
        end
    endfunction

endpackage

@@ rtl/core/irr_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module irr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/integer_radix_renderer.sv @@
// ----------------------------------------------------------------------------
// Integer radix renderer
// Renders an integer as ASCII digits in radix 2 to 36 (signed in radix 10,
// unsigned otherwise), most significant character first, final one marked.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. An item that fails the
// access or radix check gives its single error result in the next cycle and
// leaves busy low. Otherwise a bit-serial divider writes the digits, least
// significant first, into the digit store; busy stays high while they are
// divided, the capacity is checked and the digits are read back, and a minus
// sign leaves from the capacity check ahead of the digits. The final character
// leaves in the first cycle with busy low, and the next item can be taken at
// the edge that ends that cycle. A capacity failure gives its error result in
// the first cycle with busy low. Characters leave one per cycle on consecutive
// cycles and the receiver cannot stall them, so it must take every strobe as
// it comes.
// ----------------------------------------------------------------------------
module integer_radix_renderer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [irr_pkg::VALUE_W-1:0]  i_value,
    input  logic [irr_pkg::RADIX_W-1:0]  i_radix,
    input  logic [irr_pkg::CAP_W-1:0]    i_capacity,
    input  logic                         i_dest_writable,
    output logic                         o_strobe,
    output logic [irr_pkg::CHAR_W-1:0]   o_char_code,
    output logic                         o_last,
    output logic [1:0]                   o_status,
    output logic [irr_pkg::LEN_W-1:0]    o_total_length
);

    import irr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_EMIT
    } t_state;

    t_state             r_state;
    logic [INT_WIDTH-1:0] r_val;
    logic [RADIX_W-1:0] r_rem;
    logic [RADIX_W-1:0] r_radix;
    logic [CAP_W-1:0]   r_cap;
    logic               r_minus;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_idx;
    logic [BIT_W-1:0]   r_bit;
    logic               r_strobe;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;
    t_status            r_status;
    logic [LEN_W-1:0]   r_total;

    logic [RADIX_W:0]     n_shift;
    logic                 n_qbit;
    logic [RADIX_W-1:0]   n_rem;
    logic [INT_WIDTH-1:0] n_quot;
    logic [LEN_W-1:0]     n_total;
    logic [INT_WIDTH-1:0] n_pattern;
    logic                 n_neg;
    logic                 n_we;
    logic [ADDR_W-1:0]    n_raddr;
    logic [RADIX_W-1:0]   n_rdata;
    logic [CNT_W-1:0]     n_rd_idx;

    always_comb begin
        n_shift = {r_rem, r_val[INT_WIDTH-1]};
        n_qbit  = (n_shift >= {1'b0, r_radix});
        n_rem   = n_qbit ? RADIX_W'(n_shift - {1'b0, r_radix}) : n_shift[RADIX_W-1:0];
        n_quot  = {r_val[INT_WIDTH-2:0], n_qbit};
        n_total = LEN_W'(r_cnt) + LEN_W'(r_minus);
        n_pattern = i_value[INT_WIDTH-1:0];
        n_neg   = (i_radix == RADIX_DEC) && n_pattern[INT_WIDTH-1];
        n_we    = (r_state == S_DIV) && (r_bit == '0);
        n_rd_idx = (r_state == S_CHECK) ? (r_cnt - CNT_W'(1)) : (r_idx - CNT_W'(2));
        n_raddr = n_rd_idx[ADDR_W-1:0];
    end

    irr_ram #(
        .WIDTH(RADIX_W),
        .DEPTH(STORE_DEPTH)
    ) u_digit_store (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (n_rem),
        .i_raddr (n_raddr),
        .o_rdata (n_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
            r_status <= ST_OK;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_bit    <= '0;
            r_rem    <= '0;
            r_minus  <= 1'b0;
            r_radix  <= RADIX_MIN;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cap <= i_capacity;
                        if (!i_dest_writable) begin
                            r_strobe <= 1'b1;
                            r_char   <= CHAR_NONE;
                            r_last   <= 1'b1;
                            r_status <= ST_ACCESS;
                            r_total  <= '0;
                        end else if (i_radix < RADIX_MIN || i_radix > RADIX_MAX) begin
                            r_strobe <= 1'b1;
                            r_char   <= CHAR_NONE;
                            r_last   <= 1'b1;
                            r_status <= ST_RANGE;
                            r_total  <= '0;
                        end else begin
                            r_radix <= i_radix;
                            r_minus <= n_neg;
                            r_val   <= n_neg ? (INT_WIDTH'(0) - n_pattern) : n_pattern;
                            r_rem   <= '0;
                            r_bit   <= BIT_W'(INT_WIDTH - 1);
                            r_cnt   <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_val <= n_quot;
                    if (r_bit == '0) begin
                        r_rem <= '0;
                        r_bit <= BIT_W'(INT_WIDTH - 1);
                        r_cnt <= r_cnt + CNT_W'(1);
                        if (n_quot == '0 || r_cnt == CNT_W'(STORE_DEPTH - 1)) begin
                            r_state <= S_CHECK;
                        end
                    end else begin
                        r_rem <= n_rem;
                        r_bit <= r_bit - BIT_W'(1);
                    end
                end
                S_CHECK: begin
                    if ({{(CAP_W-LEN_W){1'b0}}, n_total} > r_cap) begin
                        r_strobe <= 1'b1;
                        r_char   <= CHAR_NONE;
                        r_last   <= 1'b1;
                        r_status <= ST_RANGE;
                        r_total  <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_idx <= r_cnt;
                        if (r_minus) begin
                            r_strobe <= 1'b1;
                            r_char   <= CHAR_MINUS;
                            r_last   <= 1'b0;
                            r_status <= ST_OK;
                            r_total  <= '0;
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    r_strobe <= 1'b1;
                    r_char   <= glyph(n_rdata);
                    r_status <= ST_OK;
                    r_idx    <= r_idx - CNT_W'(1);
                    if (r_idx == CNT_W'(1)) begin
                        r_last  <= 1'b1;
                        r_total <= n_total;
                        r_state <= S_IDLE;
                    end else begin
                        r_last  <= 1'b0;
                        r_total <= '0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_char_code    = r_char;
    assign o_last         = r_last;
    assign o_status       = r_status;
    assign o_total_length = r_total;

    a_err_is_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |-> o_last)
        else $error("error result without last");

    a_strobe_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start || busy))
        else $error("result without an item");

    a_rem_below_radix : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_radix))
        else $error("divider remainder reached radix");

    a_final_length : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last && o_status == ST_OK) |-> (o_total_length != '0))
        else $error("final character without length");

    a_emit_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_idx != '0 && r_idx <= r_cnt))
        else $error("character index out of range");

endmodule
